@@ rtl/resource_map_allocator_defines.svh @@
// assertion macros for the resource map allocator
`ifndef RESOURCE_MAP_ALLOCATOR_DEFINES_SVH
`define RESOURCE_MAP_ALLOCATOR_DEFINES_SVH
// assert that a implies b at every edge outside reset
`define RMA_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b in the following cycle
`define RMA_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ rtl/rma_pkg.sv @@
// package with types and constants of the resource map allocator
package rma_pkg;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_LOST   = 2'd2;
  localparam logic [1:0] ST_IGNORE = 2'd3;
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CNT_RD, S_CNT_CHK,
    S_AL_RD, S_AL_CHK, S_AL_DIV, S_AL_FIT, S_AL_WR,
    S_GB_START, S_GB_RD, S_GB_CHK, S_GB_RDN, S_GB_DEC,
    S_SH_RD, S_SH_WR, S_RM_RD, S_RM_WR, S_RM_CLR, S_INS, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quot;
    logic [30:0] rem;
  } div_rsp_t;
endpackage

@@ rtl/resource_map_allocator.sv @@
// resource map allocator top level: free range table in ram with a sequencer
//
// channel  direction  handshake          payload
// in       input      start && !busy     in_action in_addr in_size in_align
// out      output     out_valid strobe   out_granted_addr out_status
//
// the result strobe follows a sequence of steps: the used count is read first, then
// one ram read per entry walked, a run of the serial divider per entry tried by an
// aligned allocate, and one read and one write per entry shifted; the single ram
// read port and the single ram write port set the pace
// reset is synchronous and is followed by a clearing pass over all MAP_ENTRIES
// entries with busy high
// the result is shown for one cycle and cannot be stalled
module resource_map_allocator #(
  parameter int MAP_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_addr,
  input  logic [30:0] in_size,
  input  logic [30:0] in_align,
  output logic        out_valid,
  output logic [31:0] out_granted_addr,
  output logic [1:0]  out_status
);
  import rma_pkg::*;
  `include "resource_map_allocator_defines.svh"

  localparam int IW = $clog2(MAP_ENTRIES);
  localparam int CW = $clog2(MAP_ENTRIES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAP_ENTRIES - 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt, i_r, i_nxt, k_r, k_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [30:0] size_r, align_r;
  logic        act_r;
  logic [32:0] gz_r, gz_nxt;
  logic [31:0] ga_r, ga_nxt;
  logic [32:0] m_r, m_nxt;
  logic [31:0] s_r, s_nxt;
  logic [32:0] e_r, e_nxt;
  logic [31:0] ps_r, ps_nxt;
  logic [31:0] pl_r, pl_nxt;
  logic        lost_r, lost_nxt;
  logic [31:0] res_r, res_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        gbret_r, gbret_nxt;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic [31:0]   rs, rl;
  logic [32:0]   re;
  div_req_t      dreq;
  div_rsp_t      drsp;

  rma_ram #(.WIDTH(64), .DEPTH(MAP_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  rma_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign rs = rdata[63:32];
  assign rl = rdata[31:0];
  assign re = {1'b0, rs} + {1'b0, rl};

  function automatic logic [31:0] sat(input logic [33:0] v);
    return (v[33:32] != 2'b0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; i_nxt = i_r; k_nxt = k_r; addr_nxt = addr_r;
    gz_nxt = gz_r; ga_nxt = ga_r; m_nxt = m_r; s_nxt = s_r; e_nxt = e_r;
    ps_nxt = ps_r; pl_nxt = pl_r; lost_nxt = lost_r; res_nxt = res_r;
    st_nxt = st_r; gbret_nxt = gbret_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    dreq.start = 1'b0;
    dreq.dividend = m_r + {2'b0, align_r} - 33'd1;
    dreq.divisor = align_r;
    unique case (state_r)
      S_CLR: begin
        we = 1'b1; waddr = k_r[IW-1:0]; wdata = '0;
        k_nxt = k_r + 1'b1;
        if (k_r == CAP) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          addr_nxt = in_addr; res_nxt = '0; st_nxt = ST_NOFIT; lost_nxt = 1'b0;
          i_nxt = '0; state_nxt = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        raddr = i_r[IW-1:0];
        state_nxt = S_CNT_CHK;
      end
      S_CNT_CHK: begin
        if (i_r < CAP && rl != 0) begin
          i_nxt = i_r + 1'b1;
          raddr = IW'(i_r + 1'b1);
          state_nxt = S_CNT_CHK;
          if (i_r + 1'b1 >= CAP) begin
            n_nxt = i_r + 1'b1; i_nxt = '0;
            state_nxt = act_r ? S_GB_START : S_AL_RD;
          end
        end else begin
          n_nxt = i_r; i_nxt = '0;
          state_nxt = act_r ? S_GB_START : S_AL_RD;
        end
        if (state_nxt == S_GB_START) begin
          if (size_r == 0) begin
            st_nxt = ST_IGNORE; state_nxt = S_DONE;
          end else begin
            st_nxt = ST_OK;
            ga_nxt = addr_r;
            if ({1'b0, addr_r} + {2'b0, size_r} > 33'h1_0000_0000)
              gz_nxt = 33'h1_0000_0000 - {1'b0, addr_r};
            else gz_nxt = {2'b0, size_r};
            gbret_nxt = 1'b0;
          end
        end
      end
      S_AL_RD: begin
        raddr = i_r[IW-1:0];
        state_nxt = (i_r < n_r) ? S_AL_CHK : S_DONE;
      end
      S_AL_CHK: begin
        s_nxt = rs; e_nxt = re;
        if (addr_r != 0) begin
          if (rs > addr_r) state_nxt = S_DONE;
          else if (re <= {1'b0, addr_r}) begin
            i_nxt = i_r + 1'b1; state_nxt = S_AL_RD;
          end else begin
            m_nxt = {1'b0, addr_r};
            state_nxt = (align_r != 0) ? S_AL_DIV : S_AL_FIT;
          end
        end else begin
          m_nxt = {1'b0, rs};
          state_nxt = (align_r != 0) ? S_AL_DIV : S_AL_FIT;
        end
        if (state_nxt == S_AL_DIV) begin
          dreq.start = 1'b1;
          dreq.dividend = m_nxt + {2'b0, align_r} - 33'd1;
        end
      end
      S_AL_DIV: begin
        if (drsp.done) begin
          m_nxt = 33'(drsp.quot * {2'b0, align_r});
          if (drsp.quot[32]) m_nxt = 33'h1_FFFF_FFFF;
          state_nxt = S_AL_FIT;
        end
      end
      S_AL_FIT: begin
        if (m_r[32] || ({1'b0, m_r} + {3'b0, size_r}) > {1'b0, e_r}) begin
          if (addr_r != 0) state_nxt = S_DONE;
          else begin
            i_nxt = i_r + 1'b1; state_nxt = S_AL_RD;
          end
        end else begin
          res_nxt = m_r[31:0]; st_nxt = ST_OK;
          state_nxt = S_AL_WR;
        end
      end
      S_AL_WR: begin
        ga_nxt = s_r; gz_nxt = m_r - {1'b0, s_r}; gbret_nxt = 1'b1;
        if (m_r + {2'b0, size_r} == e_r) begin
          k_nxt = i_r; state_nxt = S_RM_RD;
        end else begin
          we = 1'b1; waddr = i_r[IW-1:0];
          wdata = {32'(m_r + {2'b0, size_r}), 32'(e_r - (m_r + {2'b0, size_r}))};
          state_nxt = (m_r[31:0] != s_r) ? S_GB_START : S_DONE;
        end
      end
      S_GB_START: begin
        i_nxt = '0; state_nxt = S_GB_RD;
      end
      S_GB_RD: begin
        raddr = i_r[IW-1:0];
        state_nxt = (i_r < n_r) ? S_GB_CHK : S_GB_RDN;
      end
      S_GB_CHK: begin
        if (rs <= ga_r) begin
          ps_nxt = rs; pl_nxt = rl; i_nxt = i_r + 1'b1; state_nxt = S_GB_RD;
        end else begin
          s_nxt = rs; pl_nxt = pl_r; e_nxt = {1'b0, rl}; state_nxt = S_GB_DEC;
        end
      end
      S_GB_RDN: begin
        state_nxt = S_GB_DEC;
      end
      S_GB_DEC: begin
        state_nxt = S_DONE;
        if (i_r != 0 && {1'b0, ps_r} + {1'b0, pl_r} == {1'b0, ga_r}) begin
          if (i_r < n_r && {1'b0, ga_r} + gz_r == {1'b0, s_r}) begin
            we = 1'b1; waddr = IW'(i_r - 1'b1);
            wdata = {ps_r, sat({2'b0, sat({1'b0, pl_r} + {1'b0, gz_r})} +
                               {2'b0, e_r[31:0]})};
            k_nxt = i_r; state_nxt = S_RM_RD;
            gbret_nxt = 1'b0;
          end else begin
            we = 1'b1; waddr = IW'(i_r - 1'b1);
            wdata = {ps_r, sat({1'b0, pl_r} + {1'b0, gz_r})};
          end
        end else if (i_r < n_r && {1'b0, ga_r} + gz_r == {1'b0, s_r}) begin
          we = 1'b1; waddr = i_r[IW-1:0];
          wdata = {ga_r, sat({2'b0, e_r[31:0]} + {1'b0, gz_r})};
        end else begin
          if (n_r >= CAP) begin
            if (act_r) st_nxt = ST_LOST; else lost_nxt = 1'b1;
            if (i_r >= CAP) state_nxt = S_DONE;
            else begin
              n_nxt = CAP - 1'b1; k_nxt = CAP - 1'b1; state_nxt = S_SH_RD;
            end
          end else begin
            k_nxt = n_r; state_nxt = S_SH_RD;
          end
          if (state_nxt == S_SH_RD && k_nxt == i_r) state_nxt = S_INS;
        end
      end
      S_SH_RD: begin
        raddr = IW'(k_r - 1'b1); state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        we = 1'b1; waddr = k_r[IW-1:0]; wdata = rdata;
        k_nxt = k_r - 1'b1;
        state_nxt = (k_r - 1'b1 == i_r) ? S_INS : S_SH_RD;
      end
      S_INS: begin
        we = 1'b1; waddr = i_r[IW-1:0]; wdata = {ga_r, sat({1'b0, gz_r})};
        state_nxt = S_DONE;
      end
      S_RM_RD: begin
        raddr = IW'(k_r + 1'b1);
        state_nxt = (k_r + 1'b1 < n_r) ? S_RM_WR : S_RM_CLR;
      end
      S_RM_WR: begin
        we = 1'b1; waddr = k_r[IW-1:0]; wdata = rdata;
        k_nxt = k_r + 1'b1; state_nxt = S_RM_RD;
      end
      S_RM_CLR: begin
        we = 1'b1; waddr = IW'(n_r - 1'b1); wdata = '0;
        n_nxt = n_r - 1'b1;
        state_nxt = (gbret_r && m_r[31:0] != s_r) ? S_GB_START : S_DONE;
        gbret_nxt = 1'b0;
      end
      S_DONE: begin
        if (!act_r && lost_r && st_r == ST_OK) st_nxt = ST_LOST;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      k_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      out_valid <= (state_r == S_DONE);
    end
    if (state_r == S_IDLE && start) begin
      act_r <= in_action; size_r <= in_size; align_r <= in_align;
    end
    n_r <= n_nxt; i_r <= i_nxt; addr_r <= addr_nxt;
    gz_r <= gz_nxt; ga_r <= ga_nxt; m_r <= m_nxt; s_r <= s_nxt; e_r <= e_nxt;
    ps_r <= ps_nxt; pl_r <= pl_nxt; lost_r <= lost_nxt; res_r <= res_nxt;
    st_r <= st_nxt; gbret_r <= gbret_nxt;
    if (state_r == S_DONE) begin
      out_granted_addr <= (st_nxt == ST_OK || st_nxt == ST_LOST) && !act_r ? res_r : '0;
      out_status <= st_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `RMA_ASSERT_IMP(a_no_accept_busy, busy && start, state_r != S_IDLE)
  `RMA_ASSERT_NEXT(a_done_strobe, state_r == S_DONE, out_valid)
  `RMA_ASSERT_NEXT(a_strobe_one, out_valid, !out_valid)
  `RMA_ASSERT_IMP(a_free_no_addr, out_valid && out_status == ST_IGNORE,
                  out_granted_addr == 32'd0)
endmodule

@@ rtl/rma_ram.sv @@
// generic single-port write, single-port read ram with registered read
module rma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/rma_div.sv @@
// restoring radix-2 divider, one quotient bit per cycle
module rma_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rma_pkg::div_req_t req,
  output rma_pkg::div_rsp_t rsp
);
  import rma_pkg::*;
  logic [32:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] sh;
  logic [32:0] diff;

  always_comb begin
    sh = {rem_r[30:0], q_r[32]};
    diff = {1'b0, sh} - {2'b0, d_r};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      q_nxt = req.dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        q_nxt = {q_r[31:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) d_r <= req.divisor;
  end

  assign rsp.done = busy_r && (cnt_r == 6'd1) && !req.start;
  assign rsp.quot = q_nxt;
  assign rsp.rem = rem_nxt[30:0];
endmodule
